[sv/jtap_pkg.sv]
// ----------------------------------------------------------------------------
// jtap_pkg
// Shared types, constants and the TAP next-state function for the JTAG TAP
// with debug bus access.
// ----------------------------------------------------------------------------
`default_nettype none

package jtap_pkg;

    // Instruction register length and stored opcode width.
    localparam int IR_BITS = 8;
    localparam int OPC_W   = 8;
    localparam int WORD_W  = 32;
    localparam int DR_W    = 2 * WORD_W;

    // APB register map: register i lives at byte address 4*i.
    localparam int APB_AW  = 5;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_DEVICE_ID  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OP_IDCODE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OP_SAMPLE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OP_EXTEST  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OP_BUS_WR  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OP_BUS_RD  = 3'd5;

    // Register reset values.
    localparam logic [WORD_W-1:0] DEVICE_ID_RST = '0;
    localparam logic [OPC_W-1:0]  OP_IDCODE_RST = 8'h01;
    localparam logic [OPC_W-1:0]  OP_SAMPLE_RST = 8'h02;
    localparam logic [OPC_W-1:0]  OP_EXTEST_RST = 8'h00;
    localparam logic [OPC_W-1:0]  OP_BUS_WR_RST = 8'h10;
    localparam logic [OPC_W-1:0]  OP_BUS_RD_RST = 8'h11;

    // Pattern loaded into the instruction shifter in Capture-IR.
    localparam logic [IR_BITS-1:0] IR_CAPTURE = IR_BITS'(1);

    // Input command codes.
    localparam logic [1:0] CMD_TCK   = 2'd0;
    localparam logic [1:0] CMD_TRST  = 2'd1;
    localparam logic [1:0] CMD_RDATA = 2'd2;

    // Data register length codes.
    localparam logic [1:0] LEN_1  = 2'd0;
    localparam logic [1:0] LEN_32 = 2'd1;
    localparam logic [1:0] LEN_64 = 2'd2;

    // TAP state codes.
    localparam logic [3:0] ST_TLR    = 4'd0;
    localparam logic [3:0] ST_RTI    = 4'd1;
    localparam logic [3:0] ST_SEL_DR = 4'd2;
    localparam logic [3:0] ST_CAP_DR = 4'd3;
    localparam logic [3:0] ST_SH_DR  = 4'd4;
    localparam logic [3:0] ST_EX1_DR = 4'd5;
    localparam logic [3:0] ST_PAU_DR = 4'd6;
    localparam logic [3:0] ST_EX2_DR = 4'd7;
    localparam logic [3:0] ST_UPD_DR = 4'd8;
    localparam logic [3:0] ST_SEL_IR = 4'd9;
    localparam logic [3:0] ST_CAP_IR = 4'd10;
    localparam logic [3:0] ST_SH_IR  = 4'd11;
    localparam logic [3:0] ST_EX1_IR = 4'd12;
    localparam logic [3:0] ST_PAU_IR = 4'd13;
    localparam logic [3:0] ST_EX2_IR = 4'd14;
    localparam logic [3:0] ST_UPD_IR = 4'd15;

    // Configuration register set.
    typedef struct packed {
        logic [WORD_W-1:0] device_id;
        logic [OPC_W-1:0]  opcode_idcode;
        logic [OPC_W-1:0]  opcode_sample;
        logic [OPC_W-1:0]  opcode_extest;
        logic [OPC_W-1:0]  opcode_bus_write;
        logic [OPC_W-1:0]  opcode_bus_read;
    } cfg_t;

    // One input item.
    typedef struct packed {
        logic [1:0]        cmd;
        logic              tms;
        logic              tdi;
        logic [WORD_W-1:0] read_data;
    } step_in_t;

    // One result item.
    typedef struct packed {
        logic              tdo_shifted;
        logic              tdo_pin;
        logic [3:0]        tap_state_out;
        logic              bus_request;
        logic              bus_is_write;
        logic [WORD_W-1:0] bus_address;
        logic [WORD_W-1:0] bus_write_data;
    } result_t;

    // TAP state transition on a rising TCK edge.
    function automatic logic [3:0] tap_transition(input logic [3:0] st, input logic tms);
        logic [3:0] nxt;
        unique case (st)
            ST_TLR:    nxt = tms ? ST_TLR    : ST_RTI;
            ST_RTI:    nxt = tms ? ST_SEL_DR : ST_RTI;
            ST_SEL_DR: nxt = tms ? ST_SEL_IR : ST_CAP_DR;
            ST_CAP_DR: nxt = tms ? ST_EX1_DR : ST_SH_DR;
            ST_SH_DR:  nxt = tms ? ST_EX1_DR : ST_SH_DR;
            ST_EX1_DR: nxt = tms ? ST_UPD_DR : ST_PAU_DR;
            ST_PAU_DR: nxt = tms ? ST_EX2_DR : ST_PAU_DR;
            ST_EX2_DR: nxt = tms ? ST_UPD_DR : ST_SH_DR;
            ST_UPD_DR: nxt = tms ? ST_SEL_DR : ST_RTI;
            ST_SEL_IR: nxt = tms ? ST_TLR    : ST_CAP_IR;
            ST_CAP_IR: nxt = tms ? ST_EX1_IR : ST_SH_IR;
            ST_SH_IR:  nxt = tms ? ST_EX1_IR : ST_SH_IR;
            ST_EX1_IR: nxt = tms ? ST_UPD_IR : ST_PAU_IR;
            ST_PAU_IR: nxt = tms ? ST_EX2_IR : ST_PAU_IR;
            ST_EX2_IR: nxt = tms ? ST_UPD_IR : ST_SH_IR;
            ST_UPD_IR: nxt = tms ? ST_SEL_DR : ST_RTI;
            default:   nxt = ST_TLR;
        endcase
        return nxt;
    endfunction

endpackage

`default_nettype wire

[sv/jtap_if.sv]
// ----------------------------------------------------------------------------
// jtap_if
// Valid/ready channel interfaces for the TAP input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface jtap_in_if;
    import jtap_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic              tms;
    logic              tdi;
    logic [WORD_W-1:0] read_data;

    modport source (output valid, cmd, tms, tdi, read_data, input ready);
    modport sink   (input valid, cmd, tms, tdi, read_data, output ready);
endinterface

interface jtap_out_if;
    import jtap_pkg::*;

    logic              valid;
    logic              ready;
    logic              tdo_shifted;
    logic              tdo_pin;
    logic [3:0]        tap_state_out;
    logic              bus_request;
    logic              bus_is_write;
    logic [WORD_W-1:0] bus_address;
    logic [WORD_W-1:0] bus_write_data;

    modport source (output valid, tdo_shifted, tdo_pin, tap_state_out, bus_request,
                    bus_is_write, bus_address, bus_write_data, input ready);
    modport sink   (input valid, tdo_shifted, tdo_pin, tap_state_out, bus_request,
                    bus_is_write, bus_address, bus_write_data, output ready);
endinterface

`default_nettype wire

[sv/jtap_cfg.sv]
// ----------------------------------------------------------------------------
// jtap_cfg
// APB register file holding the IDCODE word and the instruction opcodes.
// ----------------------------------------------------------------------------
`default_nettype none

module jtap_cfg
    import jtap_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [WORD_W-1:0] pwdata,
    output logic      [WORD_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg     = cfg_reg;

    // Register writes in the APB access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_id        <= DEVICE_ID_RST;
            cfg_reg.opcode_idcode    <= OP_IDCODE_RST;
            cfg_reg.opcode_sample    <= OP_SAMPLE_RST;
            cfg_reg.opcode_extest    <= OP_EXTEST_RST;
            cfg_reg.opcode_bus_write <= OP_BUS_WR_RST;
            cfg_reg.opcode_bus_read  <= OP_BUS_RD_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_DEVICE_ID: cfg_reg.device_id        <= pwdata;
                REG_OP_IDCODE: cfg_reg.opcode_idcode    <= pwdata[OPC_W-1:0];
                REG_OP_SAMPLE: cfg_reg.opcode_sample    <= pwdata[OPC_W-1:0];
                REG_OP_EXTEST: cfg_reg.opcode_extest    <= pwdata[OPC_W-1:0];
                REG_OP_BUS_WR: cfg_reg.opcode_bus_write <= pwdata[OPC_W-1:0];
                REG_OP_BUS_RD: cfg_reg.opcode_bus_read  <= pwdata[OPC_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        unique case (reg_idx)
            REG_DEVICE_ID: prdata = cfg_reg.device_id;
            REG_OP_IDCODE: prdata = WORD_W'(cfg_reg.opcode_idcode);
            REG_OP_SAMPLE: prdata = WORD_W'(cfg_reg.opcode_sample);
            REG_OP_EXTEST: prdata = WORD_W'(cfg_reg.opcode_extest);
            REG_OP_BUS_WR: prdata = WORD_W'(cfg_reg.opcode_bus_write);
            REG_OP_BUS_RD: prdata = WORD_W'(cfg_reg.opcode_bus_read);
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[sv/jtap_engine.sv]
// ----------------------------------------------------------------------------
// jtap_engine
// TAP state machine, instruction and data shifters, boundary word and debug
// bus bookkeeping. Computes one step per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jtap_engine
    import jtap_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire logic     step_en,
    input  wire step_in_t step_in,
    output result_t       res
);

    logic [3:0]         state_reg,     state_next;
    logic [OPC_W-1:0]   instr_reg,     instr_next;
    logic [IR_BITS-1:0] ir_shift_reg,  ir_shift_next;
    logic [DR_W-1:0]    dr_shift_reg,  dr_shift_next;
    logic [1:0]         dr_len_reg,    dr_len_next;
    logic               tdo_hold_reg,  tdo_hold_next;
    logic [WORD_W-1:0]  boundary_reg,  boundary_next;
    logic [WORD_W-1:0]  last_addr_reg, last_addr_next;
    logic [WORD_W-1:0]  last_rd_reg,   last_rd_next;

    logic       tdo_now;
    logic [3:0] tap_nxt;
    logic       is_idcode, is_sample, is_extest, is_bus_wr, is_bus_rd;

    // Instruction decode, first match wins.
    always_comb
    begin
        is_idcode = 1'b0;
        is_sample = 1'b0;
        is_extest = 1'b0;
        is_bus_wr = 1'b0;
        is_bus_rd = 1'b0;
        priority if (instr_reg == cfg.opcode_idcode)    is_idcode = 1'b1;
        else if (instr_reg == cfg.opcode_sample)        is_sample = 1'b1;
        else if (instr_reg == cfg.opcode_extest)        is_extest = 1'b1;
        else if (instr_reg == cfg.opcode_bus_write)     is_bus_wr = 1'b1;
        else if (instr_reg == cfg.opcode_bus_read)      is_bus_rd = 1'b1;
        else ;
    end

    // TDO level presented by the current state.
    assign tdo_now = (state_reg == ST_SH_DR) ? dr_shift_reg[0] :
                     (state_reg == ST_SH_IR) ? ir_shift_reg[0] : tdo_hold_reg;
    assign tap_nxt = tap_transition(state_reg, step_in.tms);

    // Step logic for one input item.
    always_comb
    begin
        state_next     = state_reg;
        instr_next     = instr_reg;
        ir_shift_next  = ir_shift_reg;
        dr_shift_next  = dr_shift_reg;
        dr_len_next    = dr_len_reg;
        tdo_hold_next  = tdo_hold_reg;
        boundary_next  = boundary_reg;
        last_addr_next = last_addr_reg;
        last_rd_next   = last_rd_reg;

        res.tdo_shifted    = 1'b0;
        res.bus_request    = 1'b0;
        res.bus_is_write   = 1'b0;
        res.bus_address    = '0;
        res.bus_write_data = '0;

        unique case (step_in.cmd)
            CMD_TCK:
            begin
                res.tdo_shifted = tdo_now;
                tdo_hold_next   = tdo_now;

                // Shift on leaving a shift state; TDI enters at the top of the
                // selected register length.
                if (state_reg == ST_SH_DR)
                begin
                    dr_shift_next = dr_shift_reg >> 1;
                    unique case (dr_len_reg)
                        LEN_64:  dr_shift_next[DR_W-1]   = step_in.tdi;
                        LEN_32:  dr_shift_next[WORD_W-1] = dr_shift_next[WORD_W-1] | step_in.tdi;
                        default: dr_shift_next[0]        = dr_shift_next[0] | step_in.tdi;
                    endcase
                end
                else if (state_reg == ST_SH_IR)
                begin
                    ir_shift_next = {step_in.tdi, ir_shift_reg[IR_BITS-1:1]};
                end

                // Actions on entering the new state.
                unique case (tap_nxt)
                    ST_TLR:
                    begin
                        instr_next = cfg.opcode_idcode;
                    end
                    ST_CAP_DR:
                    begin
                        if (is_idcode)
                        begin
                            dr_shift_next = DR_W'(cfg.device_id);
                            dr_len_next   = LEN_32;
                        end
                        else if (is_sample || is_extest)
                        begin
                            dr_shift_next = DR_W'(boundary_reg);
                            dr_len_next   = LEN_32;
                        end
                        else if (is_bus_wr)
                        begin
                            dr_shift_next = '0;
                            dr_len_next   = LEN_64;
                        end
                        else if (is_bus_rd)
                        begin
                            dr_shift_next = {last_addr_reg, last_rd_reg};
                            dr_len_next   = LEN_64;
                        end
                        else
                        begin
                            dr_shift_next = '0;
                            dr_len_next   = LEN_1;
                        end
                    end
                    ST_CAP_IR:
                    begin
                        ir_shift_next = IR_CAPTURE;
                    end
                    ST_UPD_DR:
                    begin
                        if (is_bus_wr || is_bus_rd)
                        begin
                            last_addr_next   = dr_shift_next[DR_W-1:WORD_W];
                            res.bus_request  = 1'b1;
                            res.bus_address  = dr_shift_next[DR_W-1:WORD_W];
                            res.bus_is_write = is_bus_wr;
                            if (is_bus_wr)
                            begin
                                res.bus_write_data = dr_shift_next[WORD_W-1:0];
                            end
                        end
                        else if (is_extest)
                        begin
                            boundary_next = dr_shift_next[WORD_W-1:0];
                        end
                    end
                    ST_UPD_IR:
                    begin
                        instr_next = OPC_W'(ir_shift_next);
                    end
                    default: ;
                endcase
                state_next = tap_nxt;
            end
            CMD_TRST:
            begin
                state_next = ST_TLR;
                instr_next = cfg.opcode_idcode;
            end
            CMD_RDATA:
            begin
                last_rd_next = step_in.read_data;
            end
            default: ;
        endcase

        res.tap_state_out = state_next;
        res.tdo_pin = (state_next == ST_SH_DR) ? dr_shift_next[0] :
                      (state_next == ST_SH_IR) ? ir_shift_next[0] : tdo_hold_next;
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_TLR;
            instr_reg     <= OP_IDCODE_RST;
            ir_shift_reg  <= '0;
            dr_shift_reg  <= '0;
            dr_len_reg    <= LEN_1;
            tdo_hold_reg  <= 1'b0;
            boundary_reg  <= '0;
            last_addr_reg <= '0;
            last_rd_reg   <= '0;
        end
        else if (step_en)
        begin
            state_reg     <= state_next;
            instr_reg     <= instr_next;
            ir_shift_reg  <= ir_shift_next;
            dr_shift_reg  <= dr_shift_next;
            dr_len_reg    <= dr_len_next;
            tdo_hold_reg  <= tdo_hold_next;
            boundary_reg  <= boundary_next;
            last_addr_reg <= last_addr_next;
            last_rd_reg   <= last_rd_next;
        end
    end

endmodule

`default_nettype wire

[sv/jtag_tap_with_debug_bus_access_core.sv]
// ----------------------------------------------------------------------------
// jtag_tap_with_debug_bus_access_core
// JTAG TAP controller with IDCODE, SAMPLE/EXTEST boundary word, BYPASS and a
// 64-bit debug bus access register, configured over APB.
//
//   Channel   Direction   Handshake           Moves
//   req_ch    in          valid/ready         one TCK edge, TRST or read return
//   rsp_ch    out         valid/ready         one result per input transaction
//   APB       in/out      psel/penable/pready IDCODE word and opcode registers
//
// One transaction is accepted per cycle. A result passes through the input
// register and then the result register, with the state update done
// combinationally between them.
// The input register accepts a new transaction while a result waits, so the
// rate is one per cycle as long as rsp_ch.ready is high; a stalled result
// holds its register and backs up into req_ch.ready.
// Reset (rst_n low) returns the TAP to Test-Logic-Reset with IDCODE loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module jtag_tap_with_debug_bus_access_core
    import jtap_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    jtap_in_if.sink                req_ch,
    jtap_out_if.source             rsp_ch,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [WORD_W-1:0] pwdata,
    output logic      [WORD_W-1:0] prdata,
    output logic                   pready
);

    cfg_t     cfg;
    logic     in_valid_reg, in_valid_next;
    step_in_t in_data_reg;
    logic     out_valid_reg, out_valid_next;
    result_t  out_data_reg;
    result_t  step_res;
    logic     advance;
    logic     in_take;

    jtap_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    jtap_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step_en (advance),
        .step_in (in_data_reg),
        .res     (step_res)
    );

    // Handshake control: the staged item steps when the result slot is free or is being taken.
    assign advance       = in_valid_reg && (!out_valid_reg || rsp_ch.ready);
    assign req_ch.ready  = !in_valid_reg || advance;
    assign in_take       = req_ch.valid && req_ch.ready;
    assign in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg.cmd       <= req_ch.cmd;
            in_data_reg.tms       <= req_ch.tms;
            in_data_reg.tdi       <= req_ch.tdi;
            in_data_reg.read_data <= req_ch.read_data;
        end
        if (advance)
        begin
            out_data_reg <= step_res;
        end
    end

    // Result channel.
    assign rsp_ch.valid          = out_valid_reg;
    assign rsp_ch.tdo_shifted    = out_data_reg.tdo_shifted;
    assign rsp_ch.tdo_pin        = out_data_reg.tdo_pin;
    assign rsp_ch.tap_state_out  = out_data_reg.tap_state_out;
    assign rsp_ch.bus_request    = out_data_reg.bus_request;
    assign rsp_ch.bus_is_write   = out_data_reg.bus_is_write;
    assign rsp_ch.bus_address    = out_data_reg.bus_address;
    assign rsp_ch.bus_write_data = out_data_reg.bus_write_data;

endmodule

`default_nettype wire

[sv/jtap_checker.sv]
// ----------------------------------------------------------------------------
// jtap_checker
// Port-level checks on the result channel of the JTAG TAP core.
// ----------------------------------------------------------------------------
`default_nettype none

module jtap_checker
    import jtap_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic [3:0]        tap_state_out,
    input wire logic              bus_request,
    input wire logic              bus_is_write,
    input wire logic [WORD_W-1:0] bus_address,
    input wire logic [WORD_W-1:0] bus_write_data
);

    // A stalled result keeps its valid, state, bus request and bus address.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(tap_state_out)
            && $stable(bus_request) && $stable(bus_address))
    else $error("result changed while stalled");

    // A bus access is issued only on entry to Update-DR.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && bus_request |-> tap_state_out == ST_UPD_DR)
    else $error("bus request outside Update-DR");

    // Without a request the bus fields are all zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !bus_request |-> !bus_is_write && bus_address == '0
            && bus_write_data == '0)
    else $error("bus fields set without a request");

    // Write data appears only on a write.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && bus_write_data != '0 |-> bus_request && bus_is_write)
    else $error("write data on a non-write result");

endmodule

bind jtag_tap_with_debug_bus_access_core jtap_checker u_jtap_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp_ch.valid),
    .rsp_ready      (rsp_ch.ready),
    .tap_state_out  (rsp_ch.tap_state_out),
    .bus_request    (rsp_ch.bus_request),
    .bus_is_write   (rsp_ch.bus_is_write),
    .bus_address    (rsp_ch.bus_address),
    .bus_write_data (rsp_ch.bus_write_data)
);

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the JTAG TAP with debug bus access. Every accepted
// transaction (TCK edge, TRST, read return or spare command) is run through a
// behavioral copy of the TAP. The expected result is queued and compared,
// field by field, with each result the block hands back. The bench opens
// with a short table that walks all sixteen TAP states. It then runs
// randomized IR and DR scans, read returns, resets and noise under several
// register settings. Both channels idle at random, and in two phases the
// receiver stalls long enough to back up the input.
// ----------------------------------------------------------------------------

module tb;
    import jtap_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int LONG_HOLD    = 200;
    localparam int DIR_ROWS     = 25;
    localparam int TYPED_ROWS   = 5;
    localparam int MAX_REPORTS  = 10;

    // Command code with no function; the block must leave its state alone.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef enum logic [2:0] {
        SEL_BYPASS,
        SEL_IDCODE,
        SEL_SAMPLE,
        SEL_EXTEST,
        SEL_BUS_WR,
        SEL_BUS_RD
    } dr_sel_e;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [WORD_W-1:0] pwdata;
    logic [WORD_W-1:0] prdata;
    logic              pready;

    jtap_in_if  req_if ();
    jtap_out_if rsp_if ();

    jtag_tap_with_debug_bus_access_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_ch  (req_if),
        .rsp_ch  (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Shadow of the TAP state and the register file, starting from reset.
    cfg_t               cfg_shadow = '{DEVICE_ID_RST, OP_IDCODE_RST, OP_SAMPLE_RST,
                                       OP_EXTEST_RST, OP_BUS_WR_RST, OP_BUS_RD_RST};
    logic [3:0]         tap_st         = ST_TLR;
    logic [OPC_W-1:0]   instr_reg      = OP_IDCODE_RST;
    logic [IR_BITS-1:0] ir_shreg       = '0;
    logic [DR_W-1:0]    dr_shreg       = '0;
    int unsigned        dr_len         = 1;
    logic               tdo_held       = 1'b0;
    logic [WORD_W-1:0]  bscan_word     = '0;
    logic [WORD_W-1:0]  bus_addr_last  = '0;
    logic [WORD_W-1:0]  rd_result_last = '0;

    result_t pending_results[$];
    int      mismatch_count = 0;
    int      items_sent     = 0;
    int      cycle_count    = 0;
    int      idle_pct       = 0;
    int      hold_asks      = 0;
    int      hold_done      = 0;

    step_in_t dir_stim [DIR_ROWS];
    result_t  dir_want [DIR_ROWS];

    // Successor state; the pair holds {next on TMS high, next on TMS low}.
    function automatic logic [3:0] tap_successor(input logic [3:0] st, input logic tms);
        logic [7:0] pair;
        case (st)
            ST_TLR:    pair = {ST_TLR,    ST_RTI};
            ST_RTI:    pair = {ST_SEL_DR, ST_RTI};
            ST_SEL_DR: pair = {ST_SEL_IR, ST_CAP_DR};
            ST_CAP_DR: pair = {ST_EX1_DR, ST_SH_DR};
            ST_SH_DR:  pair = {ST_EX1_DR, ST_SH_DR};
            ST_EX1_DR: pair = {ST_UPD_DR, ST_PAU_DR};
            ST_PAU_DR: pair = {ST_EX2_DR, ST_PAU_DR};
            ST_EX2_DR: pair = {ST_UPD_DR, ST_SH_DR};
            ST_UPD_DR: pair = {ST_SEL_DR, ST_RTI};
            ST_SEL_IR: pair = {ST_TLR,    ST_CAP_IR};
            ST_CAP_IR: pair = {ST_EX1_IR, ST_SH_IR};
            ST_SH_IR:  pair = {ST_EX1_IR, ST_SH_IR};
            ST_EX1_IR: pair = {ST_UPD_IR, ST_PAU_IR};
            ST_PAU_IR: pair = {ST_EX2_IR, ST_PAU_IR};
            ST_EX2_IR: pair = {ST_UPD_IR, ST_SH_IR};
            default:   pair = {ST_SEL_DR, ST_RTI};
        endcase
        return tms ? pair[7:4] : pair[3:0];
    endfunction

    // First matching opcode wins, so equal opcodes fall to the earlier one.
    function automatic dr_sel_e dr_select();
        if (instr_reg == cfg_shadow.opcode_idcode) return SEL_IDCODE;
        if (instr_reg == cfg_shadow.opcode_sample) return SEL_SAMPLE;
        if (instr_reg == cfg_shadow.opcode_extest) return SEL_EXTEST;
        if (instr_reg == cfg_shadow.opcode_bus_write) return SEL_BUS_WR;
        if (instr_reg == cfg_shadow.opcode_bus_read) return SEL_BUS_RD;
        return SEL_BYPASS;
    endfunction

    function automatic logic tdo_level_now();
        if (tap_st == ST_SH_DR) return dr_shreg[0];
        if (tap_st == ST_SH_IR) return ir_shreg[0];
        return tdo_held;
    endfunction

    // Apply one transaction to the shadow TAP and return the result it yields.
    function automatic result_t advance_tap(input step_in_t it);
        result_t     r;
        logic [3:0]  nxt;
        dr_sel_e     sel;
        int unsigned len;
        r = '0;
        if (it.cmd == CMD_TCK)
        begin
            r.tdo_shifted = tdo_level_now();
            if (tap_st == ST_SH_DR)
            begin
                len = (dr_len < 1 || dr_len > DR_W) ? 1 : dr_len;
                dr_shreg = (dr_shreg >> 1) | (DR_W'(it.tdi) << (len - 1));
            end
            else if (tap_st == ST_SH_IR)
            begin
                ir_shreg = {it.tdi, ir_shreg[IR_BITS-1:1]};
            end
            tdo_held = r.tdo_shifted;
            nxt = tap_successor(tap_st, it.tms);
            case (nxt)
                ST_TLR: instr_reg = cfg_shadow.opcode_idcode;
                ST_CAP_DR:
                begin
                    case (dr_select())
                        SEL_IDCODE:
                        begin
                            dr_shreg = DR_W'(cfg_shadow.device_id);
                            dr_len = WORD_W;
                        end
                        SEL_SAMPLE, SEL_EXTEST:
                        begin
                            dr_shreg = DR_W'(bscan_word);
                            dr_len = WORD_W;
                        end
                        SEL_BUS_WR:
                        begin
                            dr_shreg = '0;
                            dr_len = DR_W;
                        end
                        SEL_BUS_RD:
                        begin
                            dr_shreg = {bus_addr_last, rd_result_last};
                            dr_len = DR_W;
                        end
                        default:
                        begin
                            dr_shreg = '0;
                            dr_len = 1;
                        end
                    endcase
                end
                ST_CAP_IR: ir_shreg = IR_CAPTURE;
                ST_UPD_DR:
                begin
                    sel = dr_select();
                    if (sel == SEL_BUS_WR || sel == SEL_BUS_RD)
                    begin
                        bus_addr_last = dr_shreg[DR_W-1:WORD_W];
                        r.bus_request = 1'b1;
                        r.bus_address = dr_shreg[DR_W-1:WORD_W];
                        if (sel == SEL_BUS_WR)
                        begin
                            r.bus_is_write = 1'b1;
                            r.bus_write_data = dr_shreg[WORD_W-1:0];
                        end
                    end
                    else if (sel == SEL_EXTEST)
                    begin
                        bscan_word = dr_shreg[WORD_W-1:0];
                    end
                end
                ST_UPD_IR: instr_reg = OPC_W'(ir_shreg);
                default: ;
            endcase
            tap_st = nxt;
        end
        else if (it.cmd == CMD_TRST)
        begin
            tap_st = ST_TLR;
            instr_reg = cfg_shadow.opcode_idcode;
        end
        else if (it.cmd == CMD_RDATA)
        begin
            rd_result_last = it.read_data;
        end
        r.tdo_pin = tdo_level_now();
        r.tap_state_out = tap_st;
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input result_t want,
                                          input result_t got);
        if (mismatch_count < MAX_REPORTS)
        begin
            $display("[%0t] %s", $realtime, what);
            $display("    expected: shifted=%0b pin=%0b state=%0d req=%0b wr=%0b addr=%h data=%h",
                     want.tdo_shifted, want.tdo_pin, want.tap_state_out, want.bus_request,
                     want.bus_is_write, want.bus_address, want.bus_write_data);
            $display("    actual:   shifted=%0b pin=%0b state=%0d req=%0b wr=%0b addr=%h data=%h",
                     got.tdo_shifted, got.tdo_pin, got.tap_state_out, got.bus_request,
                     got.bus_is_write, got.bus_address, got.bus_write_data);
        end
        mismatch_count++;
    endfunction

    // Mostly short gaps, now and then a long one, none at all when idle_pct is 0.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) >= idle_pct) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Offer one transaction, wait until it is taken, then queue its result.
    task automatic send_item(input step_in_t it, input bit typed, input result_t want);
        result_t model_out;
        int      gap;
        req_if.valid     <= 1'b1;
        req_if.cmd       <= it.cmd;
        req_if.tms       <= it.tms;
        req_if.tdi       <= it.tdi;
        req_if.read_data <= it.read_data;
        do @(posedge clk); while (!req_if.ready);
        model_out = advance_tap(it);
        pending_results.push_back(typed ? want : model_out);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic tck(input logic tms, input logic tdi);
        step_in_t it;
        it.cmd = CMD_TCK;
        it.tms = tms;
        it.tdi = tdi;
        it.read_data = $urandom;
        send_item(it, 1'b0, '0);
    endtask

    task automatic send_cmd(input logic [1:0] cmd, input logic [WORD_W-1:0] rdata);
        step_in_t it;
        it.cmd = cmd;
        it.tms = rbit();
        it.tdi = rbit();
        it.read_data = rdata;
        send_item(it, 1'b0, '0);
    endtask

    // Bring the TAP to Run-Test/Idle, through TRST or by holding TMS high.
    task automatic to_idle();
        if (tap_st == ST_RTI) return;
        if (tap_st != ST_TLR)
        begin
            if ($urandom_range(0, 1) == 1)
                send_cmd(CMD_TRST, $urandom);
            else
                repeat (5) tck(1'b1, rbit());
        end
        tck(1'b0, rbit());
    endtask

    // Full IR or DR scan from Run-Test/Idle, LSB first, with the odd pause.
    task automatic scan(input bit to_ir, input logic [71:0] bits, input int nbits);
        int i;
        to_idle();
        tck(1'b1, rbit());
        if (to_ir) tck(1'b1, rbit());
        tck(1'b0, rbit());
        tck(1'b0, rbit());
        for (i = 0; i < nbits; i++)
        begin
            if (i == nbits - 1)
            begin
                tck(1'b1, bits[i]);
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                tck(1'b1, bits[i]);
                tck(1'b0, rbit());
                repeat ($urandom_range(0, 3)) tck(1'b0, rbit());
                tck(1'b1, rbit());
                tck(1'b0, rbit());
            end
            else
            begin
                tck(1'b0, bits[i]);
            end
        end
        tck(1'b1, rbit());
        tck(1'b0, rbit());
    endtask

    // One APB access, write or read, returning prdata from its access phase.
    task automatic apb_access(input logic [REG_IDX_W-1:0] idx, input logic wr,
                              input logic [WORD_W-1:0] wdata, output logic [WORD_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        logic [WORD_W-1:0] readback;
        logic [WORD_W-1:0] stored;
        apb_access(idx, 1'b1, value, readback);
        stored = (idx == REG_DEVICE_ID) ? value : WORD_W'(value[OPC_W-1:0]);
        case (idx)
            REG_DEVICE_ID: cfg_shadow.device_id        = value;
            REG_OP_IDCODE: cfg_shadow.opcode_idcode    = value[OPC_W-1:0];
            REG_OP_SAMPLE: cfg_shadow.opcode_sample    = value[OPC_W-1:0];
            REG_OP_EXTEST: cfg_shadow.opcode_extest    = value[OPC_W-1:0];
            REG_OP_BUS_WR: cfg_shadow.opcode_bus_write = value[OPC_W-1:0];
            REG_OP_BUS_RD: cfg_shadow.opcode_bus_read  = value[OPC_W-1:0];
            default: ;
        endcase
        apb_access(idx, 1'b0, '0, readback);
        if (readback !== stored)
        begin
            if (mismatch_count < MAX_REPORTS)
                $display("[%0t] register %0d read back %h, expected %h",
                         $realtime, idx, readback, stored);
            mismatch_count++;
        end
    endtask

    // Stop offering and let every queued result come back.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One randomized sequence: mostly well-formed scans, some noise.
    task automatic random_sequence();
        logic [71:0]      payload;
        logic [OPC_W-1:0] op;
        int               nbits;
        int               roll;
        payload = {8'($urandom), $urandom, $urandom};
        roll = $urandom_range(0, 99);
        if (roll < 22)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: op = cfg_shadow.opcode_bus_write;
                3, 4:    op = cfg_shadow.opcode_bus_read;
                5:       op = cfg_shadow.opcode_idcode;
                6:       op = cfg_shadow.opcode_sample;
                7:       op = cfg_shadow.opcode_extest;
                default: op = OPC_W'($urandom);
            endcase
            payload[OPC_W-1:0] = op;
            nbits = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : IR_BITS;
            scan(1'b1, payload, nbits);
        end
        else if (roll < 72)
        begin
            case (dr_select())
                SEL_BYPASS:             nbits = 1;
                SEL_BUS_WR, SEL_BUS_RD: nbits = DR_W;
                default:                nbits = WORD_W;
            endcase
            if ($urandom_range(0, 6) == 0) nbits = $urandom_range(1, 70);
            scan(1'b0, payload, nbits);
        end
        else if (roll < 82)
        begin
            case ($urandom_range(0, 5))
                0:       send_cmd(CMD_RDATA, '0);
                1:       send_cmd(CMD_RDATA, '1);
                default: send_cmd(CMD_RDATA, $urandom);
            endcase
        end
        else if (roll < 90)
        begin
            repeat ($urandom_range(1, 8))
            begin
                if ($urandom_range(0, 1) == 1)
                    tck(rbit(), rbit());
                else
                    send_cmd(2'($urandom_range(0, 3)), $urandom);
            end
        end
        else if (roll < 94)
        begin
            send_cmd(CMD_TRST, $urandom);
        end
        else if (roll < 97)
        begin
            send_cmd(CMD_SPARE, $urandom);
        end
        else
        begin
            to_idle();
            repeat ($urandom_range(1, 4)) tck(1'b0, rbit());
        end
    endtask

    // One register setting followed by a batch of random sequences.
    task automatic run_phase(input cfg_t c, input int quota, input int pct,
                             input bit squeeze, input bit drain_mid);
        int goal;
        int half;
        bit drained;
        wait_drained();
        set_reg(REG_DEVICE_ID, c.device_id);
        set_reg(REG_OP_IDCODE, {24'($urandom), c.opcode_idcode});
        set_reg(REG_OP_SAMPLE, {24'($urandom), c.opcode_sample});
        set_reg(REG_OP_EXTEST, {24'($urandom), c.opcode_extest});
        set_reg(REG_OP_BUS_WR, {24'($urandom), c.opcode_bus_write});
        set_reg(REG_OP_BUS_RD, {24'($urandom), c.opcode_bus_read});
        idle_pct = pct;
        goal = items_sent + quota;
        half = items_sent + quota / 2;
        drained = 1'b0;
        if (squeeze) hold_asks++;
        while (items_sent < goal)
        begin
            if (drain_mid && !drained && items_sent >= half)
            begin
                wait_drained();
                drained = 1'b1;
            end
            random_sequence();
        end
    endtask

    // Receiver: random back-pressure plus the long hold-off on request.
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else if (hold_done != hold_asks)
            begin
                hold_done++;
                hold_left = LONG_HOLD;
            end
            else
            begin
                hold_left = pick_gap();
            end
            rsp_if.ready <= (hold_left == 0);
        end
    end

    // Compare each accepted result with the oldest pending expectation.
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.tdo_shifted    = rsp_if.tdo_shifted;
            got.tdo_pin        = rsp_if.tdo_pin;
            got.tap_state_out  = rsp_if.tap_state_out;
            got.bus_request    = rsp_if.bus_request;
            got.bus_is_write   = rsp_if.bus_is_write;
            got.bus_address    = rsp_if.bus_address;
            got.bus_write_data = rsp_if.bus_write_data;
            if (pending_results.size() == 0)
            begin
                note_mismatch("result with no transaction pending", '0, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.tdo_shifted !== want.tdo_shifted || got.tdo_pin !== want.tdo_pin ||
                    got.tap_state_out !== want.tap_state_out ||
                    got.bus_request !== want.bus_request ||
                    got.bus_is_write !== want.bus_is_write ||
                    got.bus_address !== want.bus_address ||
                    got.bus_write_data !== want.bus_write_data)
                    note_mismatch("result differs from prediction", want, got);
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("jtag_tap_with_debug_bus_access_core verification failed");
        $finish;
    end

    // Main sequence: reset, directed walk, then the random phases.
    initial
    begin : stimulus
        int   i;
        cfg_t c;
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_if.valid     = 1'b0;
        req_if.cmd       = CMD_TCK;
        req_if.tms       = 1'b0;
        req_if.tdi       = 1'b0;
        req_if.read_data = '0;

        // Rows before the walk start from reset and have obvious results.
        dir_stim[0]  = '{CMD_TRST,  1'b0, 1'b0, 32'h0000_0000};
        dir_stim[1]  = '{CMD_TCK,   1'b1, 1'b1, 32'hFFFF_FFFF};
        dir_stim[2]  = '{CMD_RDATA, 1'b0, 1'b0, 32'hFFFF_FFFF};
        dir_stim[3]  = '{CMD_SPARE, 1'b1, 1'b1, 32'hFFFF_FFFF};
        dir_stim[4]  = '{CMD_TCK,   1'b0, 1'b0, 32'h0000_0000};
        // Walk through every TAP state, with a capture and shift on each side.
        dir_stim[5]  = '{CMD_TCK,   1'b1, 1'b0, 32'h0000_0000};
        dir_stim[6]  = '{CMD_TCK,   1'b0, 1'b1, 32'h0000_0000};
        dir_stim[7]  = '{CMD_TCK,   1'b0, 1'b1, 32'h0000_0000};
        dir_stim[8]  = '{CMD_TCK,   1'b0, 1'b1, 32'h0000_0000};
        dir_stim[9]  = '{CMD_TCK,   1'b1, 1'b1, 32'h0000_0000};
        dir_stim[10] = '{CMD_TCK,   1'b0, 1'b0, 32'h0000_0000};
        dir_stim[11] = '{CMD_TCK,   1'b1, 1'b0, 32'h0000_0000};
        dir_stim[12] = '{CMD_TCK,   1'b1, 1'b0, 32'h0000_0000};
        dir_stim[13] = '{CMD_TCK,   1'b1, 1'b0, 32'h0000_0000};
        dir_stim[14] = '{CMD_TCK,   1'b1, 1'b0, 32'h0000_0000};
        dir_stim[15] = '{CMD_TCK,   1'b0, 1'b0, 32'h0000_0000};
        dir_stim[16] = '{CMD_TCK,   1'b0, 1'b0, 32'h0000_0000};
        dir_stim[17] = '{CMD_TCK,   1'b0, 1'b1, 32'h0000_0000};
        dir_stim[18] = '{CMD_TCK,   1'b1, 1'b1, 32'h0000_0000};
        dir_stim[19] = '{CMD_TCK,   1'b0, 1'b0, 32'h0000_0000};
        dir_stim[20] = '{CMD_TCK,   1'b1, 1'b0, 32'h0000_0000};
        dir_stim[21] = '{CMD_TCK,   1'b1, 1'b0, 32'h0000_0000};
        dir_stim[22] = '{CMD_TCK,   1'b0, 1'b0, 32'h0000_0000};
        dir_stim[23] = '{CMD_TRST,  1'b0, 1'b0, 32'h0000_0000};
        dir_stim[24] = '{CMD_TCK,   1'b0, 1'b0, 32'h0000_0000};
        for (i = 0; i < DIR_ROWS; i++)
            dir_want[i] = '{1'b0, 1'b0, ST_TLR, 1'b0, 1'b0, 32'h0, 32'h0};
        dir_want[4].tap_state_out = ST_RTI;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 20;
        for (i = 0; i < DIR_ROWS; i++)
            send_item(dir_stim[i], i < TYPED_ROWS, dir_want[i]);

        // Reset values, no idling on either side.
        c = '{DEVICE_ID_RST, OP_IDCODE_RST, OP_SAMPLE_RST, OP_EXTEST_RST,
              OP_BUS_WR_RST, OP_BUS_RD_RST};
        run_phase(c, 300, 0, 1'b0, 1'b0);
        // Extreme values, with the receiver backing up the input.
        c = '{32'hFFFF_FFFF, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01};
        run_phase(c, 400, 10, 1'b1, 1'b0);
        // All opcodes equal: only IDCODE can ever be selected.
        c = '{$urandom, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A};
        run_phase(c, 250, 30, 1'b0, 1'b0);
        // Pairs of equal opcodes, and the sender drains halfway.
        c = '{32'h0000_0000, 8'h00, 8'hFF, 8'hFF, 8'h33, 8'h33};
        run_phase(c, 300, 50, 1'b0, 1'b1);
        // Fully random setting.
        c = '{$urandom, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
        run_phase(c, 350, 20, 1'b0, 1'b0);
        // Distinct fixed opcodes, another long stall.
        c = '{$urandom, 8'h3C, 8'hC3, 8'h00, 8'hA5, 8'h5A};
        run_phase(c, 300, 10, 1'b1, 1'b0);

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("jtag_tap_with_debug_bus_access_core verification clean");
        else
            $display("jtag_tap_with_debug_bus_access_core verification failed");
        $finish;
    end

endmodule
